// ===== sv/cdq_pkg.sv =====
// Shared types and constants for the circular deque unit.
// Holds command and error codes and the control word broadcast to the cell row.
// No dependencies.
package cdq_pkg;

	// Default geometry
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Entry count and size register width (fixed by the register format)
	localparam int CNT_W = 5;
	// Largest count the count field can express
	localparam int CNT_MAX = (1 << CNT_W) - 1;

	// Command codes
	typedef enum logic [1:0] {
		CMD_INS_FRONT = 2'd0,
		CMD_INS_REAR  = 2'd1,
		CMD_DEL_FRONT = 2'd2,
		CMD_DEL_REAR  = 2'd3
	} cdq_cmd_e;

	// Result error codes
	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNDERFLOW = 2'd2,
		ERR_RSVD      = 2'd3
	} cdq_err_e;

	// Control broadcast to every cell of the row
	typedef struct packed {
		logic             ins_front;
		logic             ins_rear;
		logic             del_front;
		logic [CNT_W-1:0] count;
	} cdq_ctrl_t;

endpackage

// ===== sv/cdq_cell.sv =====
// One storage cell of the deque's row.
// Holds one entry; shifts toward the rear on a front insert and toward the front
// on a front delete. Depends on cdq_pkg.
module cdq_cell #(
	parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
	parameter int CELL_IDX   = 0
) (
	input  logic                  clk,
	input  cdq_pkg::cdq_ctrl_t    ctrl,
	input  logic [DATA_WIDTH-1:0] entry_data,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] cell_data,
	output logic [DATA_WIDTH-1:0] rear_data
);

	localparam logic [cdq_pkg::CNT_W-1:0] IDX  = cdq_pkg::CNT_W'(CELL_IDX);
	localparam logic [cdq_pkg::CNT_W-1:0] RANK = cdq_pkg::CNT_W'(CELL_IDX + 1);

	logic [DATA_WIDTH-1:0] data_q;

	// Advance the entry along the row, or take a rear insert at the fill point
	always_ff @(posedge clk) begin
		if (ctrl.ins_front) begin
			data_q <= left_data;
		end else if (ctrl.del_front) begin
			data_q <= right_data;
		end else if (ctrl.ins_rear && (ctrl.count == IDX)) begin
			data_q <= entry_data;
		end
	end

	assign cell_data = data_q;

	// Drive the entry onto the rear bus only when this cell is the rear
	assign rear_data = (ctrl.count == RANK) ? data_q : '0;

endmodule

// ===== sv/circular_deque_unit.sv =====
// Circular deque unit: top level with command decode, counters and the cell row.
// Instantiates cdq_cell; uses cdq_pkg.
//
// The deque keeps its entries in order in a row of cells, front in the first
// cell and rear at the fill point; a front insert or delete shifts the whole
// row by one, a rear insert writes the cell at the fill point and a rear delete
// only lowers the count. One command is taken per clock while no result beat
// waits untaken; its result beat appears on the next cycle and holds until it
// is taken, with the error code in an output register and the other fields
// read from the deque state, which no command can move while the beat waits.
// A new command is taken in the same cycle that the result beat is taken, for
// a sustained rate of one command per cycle while results are taken. A write of
// size_in_use empties the deque; a size of zero acts as one and a size above the
// cell count acts as the cell count. No clearing pass follows reset: entries
// outside the fill are never read.
module circular_deque_unit #(
	parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
	localparam int IN_W  = ((DATA_WIDTH + 2 + 7) / 8) * 8,
	localparam int OUT_W = ((2 * DATA_WIDTH + 2 + cdq_pkg::CNT_W + 2 + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration
	input  logic                      cfg_wr_en,
	input  logic [cdq_pkg::CNT_W-1:0] cfg_wr_data,
	// Command stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_W-1:0]           s_tdata,  // cmd, entry_data, zero fill
	// Result stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// front_entry, rear_entry, is_empty, is_full, entry_count, error_code, zero fill
	output logic [OUT_W-1:0]          m_tdata
);

	localparam int CNT_W = cdq_pkg::CNT_W;
	// Cells beyond what the size register can reach are never used
	localparam int NCELL = (DEPTH < cdq_pkg::CNT_MAX) ? DEPTH : cdq_pkg::CNT_MAX;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(NCELL);
	localparam int RES_W = 2 * DATA_WIDTH + 2 + CNT_W + 2;

	logic [CNT_W-1:0]       size_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	cdq_pkg::cdq_err_e      err_q;

	logic [CNT_W-1:0]       eff_size;
	logic                   is_empty;
	logic                   is_full;
	logic                   accept;
	cdq_pkg::cdq_cmd_e      cmd;
	logic [DATA_WIDTH-1:0]  entry_data;
	logic                   is_ins;
	logic                   op_ok;
	cdq_pkg::cdq_err_e      err_next;
	cdq_pkg::cdq_ctrl_t     ctrl;

	logic [DATA_WIDTH-1:0]  cell_data [NCELL];
	logic [DATA_WIDTH-1:0]  rear_part [NCELL];
	logic [DATA_WIDTH-1:0]  front_entry;
	logic [DATA_WIDTH-1:0]  rear_entry;

	// Unpack the command beat
	assign cmd        = cdq_pkg::cdq_cmd_e'(s_tdata[1:0]);
	assign entry_data = s_tdata[DATA_WIDTH+1:2];

	// Clamp the size register to the usable range
	always_comb begin
		if (size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (size_q > CAP) begin
			eff_size = CAP;
		end else begin
			eff_size = size_q;
		end
	end

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == eff_size);

	// Take a command when the result register is free or being drained
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Decode the command and check it against fill state
	always_comb begin
		is_ins   = (cmd == cdq_pkg::CMD_INS_FRONT) || (cmd == cdq_pkg::CMD_INS_REAR);
		err_next = cdq_pkg::ERR_OK;
		if (is_ins && is_full) begin
			err_next = cdq_pkg::ERR_OVERFLOW;
		end else if (!is_ins && is_empty) begin
			err_next = cdq_pkg::ERR_UNDERFLOW;
		end
		op_ok = accept && (err_next == cdq_pkg::ERR_OK);
	end

	// Broadcast the move to the cell row
	always_comb begin
		ctrl.ins_front = op_ok && (cmd == cdq_pkg::CMD_INS_FRONT);
		ctrl.ins_rear  = op_ok && (cmd == cdq_pkg::CMD_INS_REAR);
		ctrl.del_front = op_ok && (cmd == cdq_pkg::CMD_DEL_FRONT);
		ctrl.count     = count_q;
	end

	// Size register and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= CNT_W'(16);
			count_q <= '0;
		end else if (cfg_wr_en) begin
			size_q  <= cfg_wr_data;
			count_q <= '0;
		end else if (op_ok) begin
			if (is_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Result beat holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			err_q       <= cdq_pkg::ERR_OK;
		end else if (accept) begin
			out_valid_q <= 1'b1;
			err_q       <= err_next;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Row of cells, front in cell zero
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = entry_data;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
		end
		if (i == NCELL - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner
			assign right_d = cell_data[i+1];
		end
		cdq_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CELL_IDX   (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.entry_data (entry_data),
			.left_data  (left_d),
			.right_data (right_d),
			.cell_data  (cell_data[i]),
			.rear_data  (rear_part[i])
		);
	end

	// Collect the rear entry; only the rear cell drives a nonzero word
	always_comb begin
		rear_entry = '0;
		for (int i = 0; i < NCELL; i++) begin
			rear_entry = rear_entry | rear_part[i];
		end
	end

	assign front_entry = is_empty ? '0 : cell_data[0];

	// Pack the result beat
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - RES_W){1'b0}}, err_q, count_q, is_full, is_empty,
		rear_entry, front_entry};

	// A refused insert leaves the deque full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q == cdq_pkg::ERR_OVERFLOW) |-> is_full)
		else $error("overflow reported while deque not full");

	// A refused delete leaves the deque empty
	a_unf_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q == cdq_pkg::ERR_UNDERFLOW) |-> is_empty)
		else $error("underflow reported while deque not empty");

	// Count never passes the size in use
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= eff_size)
		else $error("entry count above size in use");

	// A successful insert raises the count by one
	a_ins_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(op_ok && is_ins && !cfg_wr_en) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not raise count");

	// Rear entry reads zero while the deque is empty
	a_rear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		is_empty |-> (rear_entry == '0))
		else $error("rear entry driven while deque empty");

endmodule

// ===== test/tb_circular_deque_unit.sv =====
// Self-checking testbench for circular_deque_unit: directed corner cases, then
// random command traffic under several deque sizes and idle patterns.
// Depends on cdq_pkg and circular_deque_unit.
`timescale 1ns / 100ps

module tb_circular_deque_unit;

	localparam int DEPTH = cdq_pkg::DEPTH_DEF;
	localparam int DW    = cdq_pkg::DATA_WIDTH_DEF;
	localparam int CNT_W = cdq_pkg::CNT_W;
	localparam int IN_W  = ((DW + 2 + 7) / 8) * 8;
	localparam int OUT_W = ((2 * DW + 2 + CNT_W + 2 + 7) / 8) * 8;

	typedef struct packed {
		logic [DW-1:0]     front_entry;
		logic [DW-1:0]     rear_entry;
		logic              is_empty;
		logic              is_full;
		logic [CNT_W-1:0]  entry_count;
		cdq_pkg::cdq_err_e error_code;
	} deque_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // cmd, entry_data, zero fill
	logic             m_tvalid;
	logic             m_tready;
	// front_entry, rear_entry, is_empty, is_full, entry_count, error_code, zero fill
	logic [OUT_W-1:0] m_tdata;

	// Shadow deque state
	logic [DW-1:0]    shadow_store [DEPTH];
	logic [3:0]       front_idx = '0;
	logic [3:0]       rear_idx = '0;
	logic [CNT_W-1:0] held_cnt = '0;
	logic [CNT_W-1:0] size_reg = CNT_W'(16);

	deque_result_t    pending_results [$];
	int               mismatch_cnt = 0;
	int               src_idle_pct;
	int               sink_idle_pct;

	circular_deque_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always #5 clk = ~clk;

	// Apply one command to the shadow deque and return the result it should give
	function automatic deque_result_t apply_deque_cmd(cdq_pkg::cdq_cmd_e op,
		logic [DW-1:0] word);
		deque_result_t r;
		int unsigned sz;
		sz = (size_reg == 0) ? 1 : ((size_reg > DEPTH) ? DEPTH : size_reg);
		r.error_code = cdq_pkg::ERR_OK;
		if (op == cdq_pkg::CMD_INS_FRONT || op == cdq_pkg::CMD_INS_REAR) begin
			if (held_cnt >= sz) begin
				r.error_code = cdq_pkg::ERR_OVERFLOW;
			end else begin
				if (held_cnt == 0) begin
					front_idx = '0;
					rear_idx = '0;
					shadow_store[0] = word;
				end else if (op == cdq_pkg::CMD_INS_FRONT) begin
					front_idx = (front_idx == 0) ? 4'(sz - 1) : front_idx - 4'd1;
					shadow_store[front_idx] = word;
				end else begin
					rear_idx = (rear_idx + 1 >= sz) ? 4'd0 : rear_idx + 4'd1;
					shadow_store[rear_idx] = word;
				end
				held_cnt++;
			end
		end else if (held_cnt == 0) begin
			r.error_code = cdq_pkg::ERR_UNDERFLOW;
		end else if (held_cnt == 1) begin
			// last entry gone: indices fall back to the start
			front_idx = '0;
			rear_idx = '0;
			held_cnt = '0;
		end else begin
			if (op == cdq_pkg::CMD_DEL_FRONT)
				front_idx = (front_idx + 1 >= sz) ? 4'd0 : front_idx + 4'd1;
			else
				rear_idx = (rear_idx == 0) ? 4'(sz - 1) : rear_idx - 4'd1;
			held_cnt--;
		end
		r.front_entry = (held_cnt == 0) ? '0 : shadow_store[front_idx];
		r.rear_entry  = (held_cnt == 0) ? '0 : shadow_store[rear_idx];
		r.is_empty    = (held_cnt == 0);
		r.is_full     = (held_cnt == sz);
		r.entry_count = held_cnt;
		return r;
	endfunction

	function automatic void note_mismatch(string what, logic [DW-1:0] want, logic [DW-1:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
	endfunction

	// Take result beats at random and check each against the oldest prediction
	always @(posedge clk) begin : result_check
		deque_result_t got;
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.front_entry = m_tdata[DW-1:0];
			got.rear_entry  = m_tdata[2*DW-1:DW];
			got.is_empty    = m_tdata[2*DW];
			got.is_full     = m_tdata[2*DW+1];
			got.entry_count = m_tdata[2*DW+2 +: CNT_W];
			got.error_code  = cdq_pkg::cdq_err_e'(m_tdata[2*DW+2+CNT_W +: 2]);
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected beat", '0, got.front_entry);
			end else begin
				want = pending_results.pop_front();
				if (got.front_entry !== want.front_entry)
					note_mismatch("front_entry", want.front_entry, got.front_entry);
				if (got.rear_entry !== want.rear_entry)
					note_mismatch("rear_entry", want.rear_entry, got.rear_entry);
				if (got.is_empty !== want.is_empty)
					note_mismatch("is_empty", DW'(want.is_empty), DW'(got.is_empty));
				if (got.is_full !== want.is_full)
					note_mismatch("is_full", DW'(want.is_full), DW'(got.is_full));
				if (got.entry_count !== want.entry_count)
					note_mismatch("entry_count", DW'(want.entry_count), DW'(got.entry_count));
				if (got.error_code !== want.error_code)
					note_mismatch("error_code", DW'(want.error_code), DW'(got.error_code));
			end
		end
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Send one command beat, with a random gap first; predict at acceptance
	task automatic send_cmd(input cdq_pkg::cdq_cmd_e op, input logic [DW-1:0] word);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - DW - 2){1'b0}}, word, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(apply_deque_cmd(op, word));
	endtask

	// Hold the sender off until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the size register with the block idle; this empties the deque
	task automatic set_size(input logic [CNT_W-1:0] value);
		drain_results();
		repeat (2) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		size_reg  = value;
		front_idx = '0;
		rear_idx  = '0;
		held_cnt  = '0;
	endtask

	task automatic test_underflow_on_empty();
		send_cmd(cdq_pkg::CMD_DEL_FRONT, 32'h1234_5678);
		send_cmd(cdq_pkg::CMD_DEL_REAR, 32'hFFFF_FFFF);
	endtask

	task automatic test_front_rear_order();
		send_cmd(cdq_pkg::CMD_INS_FRONT, 32'hFFFF_FFFF);
		send_cmd(cdq_pkg::CMD_INS_REAR, 32'h0000_0000);
		// front index wraps below zero to the top of the size
		send_cmd(cdq_pkg::CMD_INS_FRONT, 32'hA5A5_A5A5);
		send_cmd(cdq_pkg::CMD_DEL_REAR, 32'h0);
		send_cmd(cdq_pkg::CMD_DEL_FRONT, 32'h0);
		send_cmd(cdq_pkg::CMD_DEL_FRONT, 32'h0);
	endtask

	task automatic test_overflow_small_size();
		set_size(CNT_W'(2));
		send_cmd(cdq_pkg::CMD_INS_REAR, 32'h0000_0001);
		send_cmd(cdq_pkg::CMD_INS_FRONT, 32'h0000_0002);
		send_cmd(cdq_pkg::CMD_INS_REAR, 32'h0000_0003);
		send_cmd(cdq_pkg::CMD_INS_FRONT, 32'h0000_0004);
		send_cmd(cdq_pkg::CMD_DEL_REAR, 32'h0);
		send_cmd(cdq_pkg::CMD_DEL_FRONT, 32'h0);
		send_cmd(cdq_pkg::CMD_DEL_REAR, 32'h0);
	endtask

	task automatic test_size_zero_clamp();
		// zero acts as a size of one
		set_size(CNT_W'(0));
		send_cmd(cdq_pkg::CMD_INS_REAR, 32'h5A5A_5A5A);
		send_cmd(cdq_pkg::CMD_INS_FRONT, 32'hC3C3_C3C3);
		send_cmd(cdq_pkg::CMD_DEL_REAR, 32'h0);
	endtask

	task automatic test_size_write_clears();
		set_size(CNT_W'(16));
		send_cmd(cdq_pkg::CMD_INS_REAR, 32'h8000_0000);
		send_cmd(cdq_pkg::CMD_INS_REAR, 32'h0000_0001);
		set_size(CNT_W'(5));
		send_cmd(cdq_pkg::CMD_DEL_FRONT, 32'h0);
	endtask

	// Random commands in runs that lean toward filling, draining or neither
	task automatic run_random_segment(input int n_items);
		int                fill_bias;
		int                pick;
		cdq_pkg::cdq_cmd_e op;
		logic [DW-1:0]     word;
		fill_bias = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 24 == 0) begin
				pick = $urandom_range(2);
				fill_bias = (pick == 0) ? 15 : ((pick == 1) ? 50 : 85);
			end
			if (i == n_items / 2)
				drain_results();
			if ($urandom_range(99) < fill_bias)
				op = $urandom_range(1) ? cdq_pkg::CMD_INS_REAR : cdq_pkg::CMD_INS_FRONT;
			else
				op = $urandom_range(1) ? cdq_pkg::CMD_DEL_REAR : cdq_pkg::CMD_DEL_FRONT;
			pick = $urandom_range(15);
			word = (pick == 0) ? '0 : ((pick == 1) ? '1 : DW'($urandom));
			send_cmd(op, word);
		end
	endtask

	task automatic test_random_traffic();
		logic [CNT_W-1:0] size_plan [12];
		size_plan = '{5'd16, 5'd1, 5'd9, 5'd31, 5'd2, 5'd15,
			5'd4, 5'd24, 5'd0, 5'd12, 5'd3, 5'd16};
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct  = (phase == 0) ? 17 : ((phase == 1) ? 55 : 0);
			sink_idle_pct = (phase == 0) ? 55 : ((phase == 1) ? 17 : 0);
			for (int s = 0; s < 4; s++) begin
				set_size(size_plan[phase * 4 + s]);
				run_random_segment(146);
			end
		end
	endtask

	// Bound the run
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		src_idle_pct  = 17;
		sink_idle_pct = 55;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_underflow_on_empty();
		test_front_rear_order();
		test_overflow_small_size();
		test_size_zero_clamp();
		test_size_write_clears();
		test_random_traffic();

		drain_results();
		repeat (5) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cdq_pkg.sv
sv/cdq_cell.sv
sv/circular_deque_unit.sv
test/tb_circular_deque_unit.sv
